[rtl/core/hrf_pkg.sv]
// Shared types and constants for the HLL interface flux block.
// No dependencies.
package hrf_pkg;

   localparam int TOL_BITS = 16;

   typedef enum logic [1:0] {
      REGION_LEFT  = 2'd0,
      REGION_RIGHT = 2'd1,
      REGION_STAR  = 2'd2
   } region_type;

   // Per-transaction control travelling beside the datapath
   typedef struct packed {
      logic       valid;
      logic       neg;
      region_type region;
      logic       speed_ovf;
      logic       quo_ovf;
      logic       div_fault;
   } ctrl_type;

endpackage

[rtl/core/hrf_prep.sv]
// Front pipeline: products, region choice, numerator and divisor setup.
// Depends on hrf_pkg.
module hrf_prep
   import hrf_pkg::*;
#(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic [TOL_BITS-1:0]         tol,
   input  logic signed [WORD_BITS-1:0] s1,
   input  logic signed [WORD_BITS-1:0] s2,
   input  logic signed [WORD_BITS-1:0] ql,
   input  logic signed [WORD_BITS-1:0] qr,
   input  logic signed [WORD_BITS-1:0] fl,
   input  logic signed [WORD_BITS-1:0] fr,
   output ctrl_type                    ctrl_out,
   output logic [((3*WORD_BITS > 2*WORD_BITS+FRAC_BITS) ? 3*WORD_BITS
                  : 2*WORD_BITS+FRAC_BITS)+1:0] rem_out,
   output logic [WORD_BITS+FRAC_BITS:0] dmag_out,
   output logic [WORD_BITS-1:0]        flux_out,
   output logic [WORD_BITS-2:0]        amax_out
);
   localparam int W  = WORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int NB = ((3*W > 2*W+F) ? 3*W : 2*W+F) + 2;
   localparam int DB = W + 1 + F;
   localparam int CW = ((2*W > TOL_BITS+F+1) ? 2*W : TOL_BITS+F+1) + 1;

   // stage a
   logic [W-1:0] mag_l, mag_r, amax;
   logic signed [2*W-1:0] p1_in, p2_in, prod_in;
   logic signed [W:0] dq_in, den_in;
   logic small_in, s1pos_in, sovf_in;
   logic [W-2:0] amax_in;

   logic va_ff;
   logic signed [2*W-1:0] p1_ff, p2_ff, prod_ff;
   logic signed [W:0] dq_ff, den_a_ff;
   logic small_ff, s1pos_ff, sovf_a_ff;
   logic [W-2:0] amax_a_ff;
   logic [W-1:0] fl_a_ff, fr_a_ff;

   // stage b
   logic signed [2*W:0] t12_in, pp_hi_in;
   logic signed [2*W+1:0] pp_lo_in;
   logic signed [CW-1:0] prod_c, tol_c;
   region_type region_in;
   ctrl_type ctrl_b_in, ctrl_b_ff;
   logic [W-1:0] flux_b_in, flux_b_ff;
   logic signed [2*W:0] t12_ff, pp_hi_ff;
   logic signed [2*W+1:0] pp_lo_ff;
   logic signed [W:0] den_b_ff;
   logic [W-2:0] amax_b_ff;

   // stage c
   logic signed [NB-1:0] num_in, num_ff;
   logic [W:0] den_mag;
   logic [DB-1:0] dmag_c_in, dmag_c_ff;
   ctrl_type ctrl_c_in, ctrl_c_ff;
   logic [W-1:0] flux_c_ff;
   logic [W-2:0] amax_c_ff;

   // stage d
   logic [NB-1:0] numu, half, rem_d_in, rem_d_ff;
   ctrl_type ctrl_d_ff;
   logic [DB-1:0] dmag_d_ff;
   logic [W-1:0] flux_d_ff;
   logic [W-2:0] amax_d_ff;

   // stage e
   ctrl_type ctrl_e_in, ctrl_e_ff;
   logic [NB-1:0] rem_e_ff;
   logic [DB-1:0] dmag_e_ff;
   logic [W-1:0] flux_e_ff;
   logic [W-2:0] amax_e_ff;

   always_comb begin
      mag_l    = s1[W-1] ? W'(-s1) : s1;
      mag_r    = s2[W-1] ? W'(-s2) : s2;
      amax     = (mag_l > mag_r) ? mag_l : mag_r;
      sovf_in  = amax[W-1];
      amax_in  = sovf_in ? '1 : amax[W-2:0];
      small_in = (mag_l <= W'(tol)) && (mag_r <= W'(tol));
      s1pos_in = !s1[W-1] && (|s1);
      p1_in    = s2 * fl;
      p2_in    = s1 * fr;
      prod_in  = s1 * s2;
      dq_in    = qr - ql;
      den_in   = s2 - s1;
   end

   always_comb begin
      t12_in   = p1_ff - p2_ff;
      pp_hi_in = $signed(prod_ff[2*W-1:W]) * dq_ff;
      pp_lo_in = $signed({1'b0, prod_ff[W-1:0]}) * dq_ff;
      prod_c   = CW'(prod_ff);
      tol_c    = CW'(tol) << F;
      if (small_ff) begin
         region_in = REGION_LEFT;
      end else if (prod_c > tol_c) begin
         region_in = s1pos_ff ? REGION_LEFT : REGION_RIGHT;
      end else begin
         region_in = REGION_STAR;
      end
      ctrl_b_in.valid     = va_ff;
      ctrl_b_in.neg       = 1'b0;
      ctrl_b_in.region    = region_in;
      ctrl_b_in.speed_ovf = sovf_a_ff;
      ctrl_b_in.quo_ovf   = 1'b0;
      ctrl_b_in.div_fault = (region_in == REGION_STAR) && (den_a_ff == '0);
      flux_b_in = (region_in == REGION_RIGHT) ? fr_a_ff : fl_a_ff;
   end

   always_comb begin
      num_in  = (NB'(t12_ff) <<< F) + (NB'(pp_hi_ff) <<< W) + NB'(pp_lo_ff);
      den_mag = den_b_ff[W] ? (W+1)'(-den_b_ff) : den_b_ff;
      dmag_c_in = DB'(den_mag) << F;
      ctrl_c_in = ctrl_b_ff;
      ctrl_c_in.neg = num_in[NB-1] ^ den_b_ff[W];
   end

   // magnitude and rounding offset in one add
   always_comb begin
      numu     = num_ff;
      half     = NB'(dmag_c_ff >> 1);
      rem_d_in = num_ff[NB-1] ? (half - numu) : (numu + half);
   end

   // quotient would not fit the word
   always_comb begin
      ctrl_e_in = ctrl_d_ff;
      ctrl_e_in.quo_ovf = rem_d_ff >= (NB'(dmag_d_ff) << W);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff     <= 1'b0;
         ctrl_b_ff <= '0;
         ctrl_c_ff <= '0;
         ctrl_d_ff <= '0;
         ctrl_e_ff <= '0;
      end else if (advance) begin
         va_ff     <= in_valid;
         ctrl_b_ff <= ctrl_b_in;
         ctrl_c_ff <= ctrl_c_in;
         ctrl_d_ff <= ctrl_c_ff;
         ctrl_e_ff <= ctrl_e_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_ff     <= p1_in;
         p2_ff     <= p2_in;
         prod_ff   <= prod_in;
         dq_ff     <= dq_in;
         den_a_ff  <= den_in;
         small_ff  <= small_in;
         s1pos_ff  <= s1pos_in;
         sovf_a_ff <= sovf_in;
         amax_a_ff <= amax_in;
         fl_a_ff   <= fl;
         fr_a_ff   <= fr;

         t12_ff    <= t12_in;
         pp_hi_ff  <= pp_hi_in;
         pp_lo_ff  <= pp_lo_in;
         den_b_ff  <= den_a_ff;
         flux_b_ff <= flux_b_in;
         amax_b_ff <= amax_a_ff;

         num_ff    <= num_in;
         dmag_c_ff <= dmag_c_in;
         flux_c_ff <= flux_b_ff;
         amax_c_ff <= amax_b_ff;

         rem_d_ff  <= rem_d_in;
         dmag_d_ff <= dmag_c_ff;
         flux_d_ff <= flux_c_ff;
         amax_d_ff <= amax_c_ff;

         rem_e_ff  <= rem_d_ff;
         dmag_e_ff <= dmag_d_ff;
         flux_e_ff <= flux_d_ff;
         amax_e_ff <= amax_d_ff;
      end
   end

   assign ctrl_out = ctrl_e_ff;
   assign rem_out  = rem_e_ff;
   assign dmag_out = dmag_e_ff;
   assign flux_out = flux_e_ff;
   assign amax_out = amax_e_ff;

endmodule

[rtl/core/hrf_div_cell.sv]
// One restoring-division cell: settles one quotient bit per transaction.
// Depends on hrf_pkg.
module hrf_div_cell
   import hrf_pkg::*;
#(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16,
   parameter int SHIFT     = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  ctrl_type                    ctrl_in,
   input  logic [((3*WORD_BITS > 2*WORD_BITS+FRAC_BITS) ? 3*WORD_BITS
                  : 2*WORD_BITS+FRAC_BITS)+1:0] rem_in,
   input  logic [WORD_BITS+FRAC_BITS:0] dmag_in,
   input  logic [WORD_BITS-1:0]        quo_in,
   input  logic [WORD_BITS-1:0]        flux_in,
   input  logic [WORD_BITS-2:0]        amax_in,
   output ctrl_type                    ctrl_out,
   output logic [((3*WORD_BITS > 2*WORD_BITS+FRAC_BITS) ? 3*WORD_BITS
                  : 2*WORD_BITS+FRAC_BITS)+1:0] rem_out,
   output logic [WORD_BITS+FRAC_BITS:0] dmag_out,
   output logic [WORD_BITS-1:0]        quo_out,
   output logic [WORD_BITS-1:0]        flux_out,
   output logic [WORD_BITS-2:0]        amax_out
);
   localparam int W  = WORD_BITS;
   localparam int NB = ((3*W > 2*W+FRAC_BITS) ? 3*W : 2*W+FRAC_BITS) + 2;

   logic [NB-1:0] trial, rem_in_n, rem_ff;
   logic          take;
   logic [W-1:0]  quo_in_n, quo_ff;
   ctrl_type      ctrl_ff;
   logic [WORD_BITS+FRAC_BITS:0] dmag_ff;
   logic [W-1:0]  flux_ff;
   logic [W-2:0]  amax_ff;

   always_comb begin
      trial    = NB'(dmag_in) << SHIFT;
      take     = rem_in >= trial;
      rem_in_n = take ? (rem_in - trial) : rem_in;
      quo_in_n = quo_in;
      quo_in_n[SHIFT] = take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in_n;
         quo_ff  <= quo_in_n;
         dmag_ff <= dmag_in;
         flux_ff <= flux_in;
         amax_ff <= amax_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign rem_out  = rem_ff;
   assign dmag_out = dmag_ff;
   assign quo_out  = quo_ff;
   assign flux_out = flux_ff;
   assign amax_out = amax_ff;

endmodule

[rtl/core/hll_riemann_flux.sv]
// HLL approximate Riemann solver flux, top level.
// Depends on hrf_pkg, hrf_prep and hrf_div_cell.
//
//   channel  ports     direction  payload
//   request  req_*     in         speeds, states, fluxes (signed, WORD_BITS)
//   response rsp_*     out        interface flux, max speed, region, flags
//   csr      csr_*     in         zero_tolerance (16 bits)
//
// Five front stages, one division cell per quotient bit, one output
// register. One transaction enters per cycle unless a stalled response
// holds the pipeline; the quotient cells settle one bit each as data moves.
// Reset is synchronous and clears only valid bits, control words and the tolerance.
// A stalled response with valid held freezes the whole pipeline, and
// req_stall follows it; empty slots are not squeezed out.
module hll_riemann_flux
   import hrf_pkg::*;
#(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [WORD_BITS-1:0] req_speed_left,
   input  logic signed [WORD_BITS-1:0] req_speed_right,
   input  logic signed [WORD_BITS-1:0] req_state_left,
   input  logic signed [WORD_BITS-1:0] req_state_right,
   input  logic signed [WORD_BITS-1:0] req_flux_left,
   input  logic signed [WORD_BITS-1:0] req_flux_right,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [WORD_BITS-1:0] rsp_interface_flux,
   output logic [WORD_BITS-2:0]        rsp_max_speed,
   output logic [1:0]                  rsp_region,
   output logic                        rsp_overflow,
   output logic                        rsp_divide_fault,
   // configuration
   input  logic                        csr_wr_en,
   input  logic [TOL_BITS-1:0]         csr_wr_data
);
   localparam int W  = WORD_BITS;
   localparam int NB = ((3*W > 2*W+FRAC_BITS) ? 3*W : 2*W+FRAC_BITS) + 2;
   localparam int DB = W + 1 + FRAC_BITS;

   logic [TOL_BITS-1:0] tol_ff;
   logic                advance;

   // cell chain buses, index k feeds cell k
   ctrl_type      ctrl_ch [0:W];
   logic [NB-1:0] rem_ch  [0:W];
   logic [DB-1:0] dmag_ch [0:W];
   logic [W-1:0]  quo_ch  [0:W];
   logic [W-1:0]  flux_ch [0:W];
   logic [W-2:0]  amax_ch [0:W];

   // final select and saturation
   ctrl_type     fin;
   logic [W-1:0] bound, mag, star_flux, flux_in;
   logic         quo_sat, ovf_in;

   logic         rsp_valid_ff;
   logic [W-1:0] rsp_flux_ff;
   logic [W-2:0] rsp_amax_ff;
   region_type   rsp_region_ff;
   logic         rsp_ovf_ff, rsp_dfault_ff;

   // pipeline moves unless a finished transaction is held at the output
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   hrf_prep #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_prep (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .tol      (tol_ff),
      .s1       (req_speed_left),
      .s2       (req_speed_right),
      .ql       (req_state_left),
      .qr       (req_state_right),
      .fl       (req_flux_left),
      .fr       (req_flux_right),
      .ctrl_out (ctrl_ch[0]),
      .rem_out  (rem_ch[0]),
      .dmag_out (dmag_ch[0]),
      .flux_out (flux_ch[0]),
      .amax_out (amax_ch[0])
   );

   assign quo_ch[0] = '0;

   // cell k decides quotient bit W-1-k, most significant first
   for (genvar k = 0; k < W; k++) begin : g_cell
      hrf_div_cell #(
         .WORD_BITS (WORD_BITS),
         .FRAC_BITS (FRAC_BITS),
         .SHIFT     (W-1-k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .ctrl_in  (ctrl_ch[k]),
         .rem_in   (rem_ch[k]),
         .dmag_in  (dmag_ch[k]),
         .quo_in   (quo_ch[k]),
         .flux_in  (flux_ch[k]),
         .amax_in  (amax_ch[k]),
         .ctrl_out (ctrl_ch[k+1]),
         .rem_out  (rem_ch[k+1]),
         .dmag_out (dmag_ch[k+1]),
         .quo_out  (quo_ch[k+1]),
         .flux_out (flux_ch[k+1]),
         .amax_out (amax_ch[k+1])
      );
   end

   // rem_ch[W] (spent remainder) and dmag_ch[W] (divisor) are not needed further
   always_comb begin
      fin       = ctrl_ch[W];
      bound     = fin.neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      quo_sat   = fin.quo_ovf || (quo_ch[W] > bound);
      mag       = quo_sat ? bound : quo_ch[W];
      star_flux = fin.neg ? (~mag + 1'b1) : mag;
      if ((fin.region == REGION_STAR) && !fin.div_fault) begin
         flux_in = star_flux;
         ovf_in  = quo_sat || fin.speed_ovf;
      end else begin
         flux_in = flux_ch[W];
         ovf_in  = fin.speed_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= fin.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_flux_ff   <= flux_in;
         rsp_amax_ff   <= amax_ch[W];
         rsp_region_ff <= fin.region;
         rsp_ovf_ff    <= ovf_in;
         rsp_dfault_ff <= fin.div_fault;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_interface_flux = rsp_flux_ff;
   assign rsp_max_speed      = rsp_amax_ff;
   assign rsp_region         = rsp_region_ff;
   assign rsp_overflow       = rsp_ovf_ff;
   assign rsp_divide_fault   = rsp_dfault_ff;

endmodule

[dv/tb.sv]
// Self-checking bench for hll_riemann_flux: drives random and corner transactions
// and compares every response against an in-bench HLL flux predictor.
// Depends on hrf_pkg and the hll_riemann_flux RTL.
`timescale 1ns / 100ps

module tb
   import hrf_pkg::*;
();

   localparam int WB = 32;
   localparam int FB = 16;
   localparam int LATENCY = WB + 6;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct {
      logic signed [WB-1:0] flux;
      logic [WB-2:0]        max_speed;
      region_type           region;
      logic                 overflow;
      logic                 divide_fault;
   } flux_result_type;

   // Expected-response store; the HLL predictor lives in note_request
   class scoreboard_type;
      flux_result_type pending[$];
      logic [TOL_BITS-1:0] tolerance;
      int errors;

      function new();
         tolerance = '0;
         errors = 0;
      endfunction

      function void note_request(logic signed [WB-1:0] s1, logic signed [WB-1:0] s2,
                                 logic signed [WB-1:0] ql, logic signed [WB-1:0] qr,
                                 logic signed [WB-1:0] fl, logic signed [WB-1:0] fr);
         flux_result_type r;
         logic signed [127:0] prod, tol, num, den, nmag, dmag, q, bound;
         logic [WB:0] a1, a2, amax;
         logic neg;
         r.overflow = 1'b0;
         r.divide_fault = 1'b0;
         a1 = s1 < 0 ? 33'(-$signed({s1[WB-1], s1})) : 33'({1'b0, s1});
         a2 = s2 < 0 ? 33'(-$signed({s2[WB-1], s2})) : 33'({1'b0, s2});
         prod = 128'(s1) * 128'(s2);
         tol = 128'({1'b0, tolerance}) <<< FB;
         if (a1 <= tolerance && a2 <= tolerance) r.region = REGION_LEFT;
         else if (prod > tol) r.region = (s1 > 0) ? REGION_LEFT : REGION_RIGHT;
         else r.region = REGION_STAR;
         r.flux = fl;
         if (r.region == REGION_RIGHT) r.flux = fr;
         if (r.region == REGION_STAR) begin
            den = 128'(s2) - 128'(s1);
            if (den == 0) r.divide_fault = 1'b1;
            else begin
               num = ((128'(s2) * 128'(fl) - 128'(s1) * 128'(fr)) <<< FB)
                     + prod * (128'(qr) - 128'(ql));
               neg = (num < 0) != (den < 0);
               nmag = num < 0 ? -num : num;
               dmag = (den < 0 ? -den : den) <<< FB;
               q = (nmag + (dmag >>> 1)) / dmag;
               bound = neg ? 128'sd2147483648 : 128'sd2147483647;
               if (q > bound) begin
                  q = bound;
                  r.overflow = 1'b1;
               end
               r.flux = neg ? WB'(-q) : WB'(q);
            end
         end
         amax = a1 > a2 ? a1 : a2;
         if (amax > 33'h7fffffff) begin
            amax = 33'h7fffffff;
            r.overflow = 1'b1;
         end
         r.max_speed = amax[WB-2:0];
         pending.push_back(r);
      endfunction

      function void check_response(logic signed [WB-1:0] flux, logic [WB-2:0] ms,
                                   logic [1:0] region, logic ovf, logic dfault);
         flux_result_type e;
         if (pending.size() == 0) begin
            $error("response with no transaction outstanding");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (flux !== e.flux) begin
            $error("interface_flux expected %h actual %h", e.flux, flux); errors++;
         end
         if (ms !== e.max_speed) begin
            $error("max_speed expected %h actual %h", e.max_speed, ms); errors++;
         end
         if (region !== e.region) begin
            $error("region expected %0d actual %0d", e.region, region); errors++;
         end
         if (ovf !== e.overflow) begin
            $error("overflow expected %b actual %b", e.overflow, ovf); errors++;
         end
         if (dfault !== e.divide_fault) begin
            $error("divide_fault expected %b actual %b", e.divide_fault, dfault);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall;
   logic signed [WB-1:0] req_speed_left = 0, req_speed_right = 0;
   logic signed [WB-1:0] req_state_left = 0, req_state_right = 0;
   logic signed [WB-1:0] req_flux_left = 0, req_flux_right = 0;
   logic rsp_valid, rsp_stall = 0;
   logic signed [WB-1:0] rsp_interface_flux;
   logic [WB-2:0] rsp_max_speed;
   logic [1:0] rsp_region;
   logic rsp_overflow, rsp_divide_fault;
   logic csr_wr_en = 0;
   logic [TOL_BITS-1:0] csr_wr_data = 0;

   scoreboard_type sb = new();
   longint cycle_count = 0;
   bit quiet_tail = 0;   // no idling near the end of the run

   hll_riemann_flux #(.WORD_BITS(WB), .FRAC_BITS(FB)) DUT (.*);

   initial forever #2 clock = ~clock;

   // Response side: random stall bursts, check at each accepted response
   initial begin
      int burst;
      burst = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_response(rsp_interface_flux, rsp_max_speed, rsp_region,
                              rsp_overflow, rsp_divide_fault);
         if (burst > 0) burst--;
         else if (!quiet_tail && $urandom_range(0, 9) == 0) burst = $urandom_range(1, 3);
         rsp_stall <= (burst > 0);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Random speed biased toward small magnitudes and the region boundaries
   function automatic logic signed [WB-1:0] pick_speed();
      unique case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $signed(32'($urandom_range(0, 131071))) - 65536;
         2: return $signed(32'($urandom_range(0, 2047))) - 1024;
         3: return 32'h80000000;
         default: return $signed(32'($urandom_range(0, 33554431))) - 16777216;
      endcase
   endfunction

   task automatic send_item(logic signed [WB-1:0] s1, logic signed [WB-1:0] s2,
                            logic signed [WB-1:0] ql, logic signed [WB-1:0] qr,
                            logic signed [WB-1:0] fl, logic signed [WB-1:0] fr);
      int gap;
      gap = quiet_tail ? 0 : ($urandom_range(0, 7) == 0 ? $urandom_range(1, 3) : 0);
      repeat (gap) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_speed_left <= s1;  req_speed_right <= s2;
      req_state_left <= ql;  req_state_right <= qr;
      req_flux_left <= fl;   req_flux_right <= fr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(s1, s2, ql, qr, fl, fr);
   endtask

   // Idle the sender until the pipeline has drained
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [TOL_BITS-1:0] value);
      csr_wr_en <= 1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.tolerance = value;
   endtask

   initial begin
      logic [TOL_BITS-1:0] tol_set[5];
      tol_set = '{16'hffff, 16'h0001, 16'h0100, 16'h8000, 16'h0000};
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: tolerance at reset value 0
      send_item(0, 0, 5, 6, 7, 8);                                // both speeds zero
      send_item(32'h00010000, 32'h00020000, 1, 2, 3, 4);          // left upwind
      send_item(-32'sh00020000, -32'sh00010000, 1, 2, 3, 4);      // right upwind
      send_item(-32'sh00010000, 32'h00010000, 32'h10000, 32'h20000, 32'h30000, -32'sh40000);
      send_item(0, 32'h00010000, 9, 10, 11, 12);                  // product zero, star
      send_item(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                32'h7fffffff, 32'h80000000);                      // extremes, saturation
      send_item(32'h80000000, 32'h80000000, 0, 0, 1, 2);          // max speed saturates
      send_item(-1, 1, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
      send_item(32'h7fffffff, -32'sh7fffffff, 3, -3, 32'h7fffffff, 32'h80000000);
      drain();
      write_tolerance(16'hffff);
      send_item(32'h0000ffff, -32'sh0000ffff, 1, 2, 3, 4);        // within tolerance
      send_item(32'h00010000, 32'h00010000, 1, 2, 3, 4);          // equal speeds above tolerance: left upwind
      send_item(-32'sh00010000, -32'sh00010000, 5, 6, 7, 8);
      send_item(32'h00010000, 32'h0000ffff, 5, 6, 7, 8);
      send_item(32'h00010001, 32'h00010000, 1, 2, -3, -4);
      drain();

      // Random phases across tolerance settings
      foreach (tol_set[p]) begin
         write_tolerance(p == 2 ? 16'($urandom) : tol_set[p]);
         if (p == 4) quiet_tail = 1;
         repeat (310) begin
            logic signed [WB-1:0] s1, s2;
            s1 = pick_speed();
            s2 = ($urandom_range(0, 9) == 0) ? s1 : pick_speed();
            send_item(s1, s2, $urandom, $urandom, $urandom, $urandom);
         end
         drain();
      end

      if (sb.errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
